@@ src/ats_pkg.sv @@
// package for the accelerating trailing stop block
// request and response payload structs, state codes and fixed widths; no dependencies
`default_nettype none
package ats_pkg;
   localparam int unsigned INST_W  = 10;
   localparam int unsigned PRICE_W = 32;
   localparam int unsigned START_W = 16;
   localparam int unsigned SPEED_W = 24;
   localparam int unsigned CSR_W   = 24;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_START = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED = 1'b1;

   typedef struct packed {
      logic [INST_W-1:0]  instrument;
      logic [PRICE_W-1:0] close_price;
      logic               first_day;
   } req_type;

   typedef struct packed {
      logic [INST_W-1:0]  instrument_out;
      logic [PRICE_W-1:0] reference_level;
      logic               sold_flag;
      logic               switched;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_MUL,
      ST_DIV,
      ST_SCALE,
      ST_SCALE_HI,
      ST_CLAMP,
      ST_DECIDE,
      ST_BAND,
      ST_WRITE,
      ST_RESP
   } state_type;
endpackage
`default_nettype wire

@@ src/accelerating_trailing_stop_reference.sv @@
// accelerating trailing stop reference level, top level
// uses ats_pkg; holds the per-instrument state memory, a serial divider and the sequencer
`default_nettype none
// One request is worked at a time. A request with a nonzero previous close passes through
// the bit-serial divider of |close-prev|*speed by the previous close; a first-day request
// goes from the read straight to the band state, and one with previous close zero skips
// the divider and the scaling. A switch of state passes through the band state for the band
// product. The block is ready for the next request in the same cycle the response is raised,
// while that response may still wait in the output register; a finished request holds in
// its last state only if the previous response has still not been taken. The per-instrument
// state sits in one memory with a registered read; it is read, updated and written
// back before the next request is taken, so no forwarding is needed. The memory has no
// reset: an instrument must see its first-day request before any other.
module accelerating_trailing_stop_reference #(
   parameter int unsigned INSTRUMENTS = 1024,
   parameter int unsigned PRICE_BITS  = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire ats_pkg::req_type                    req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output ats_pkg::rsp_type                         rsp_data,
   input  wire logic                                csr_write,
   input  wire logic [ats_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [ats_pkg::CSR_W-1:0]           csr_data
);
   localparam int unsigned AW   = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;
   localparam int unsigned PB   = PRICE_BITS;
   localparam int unsigned NW   = PB + ats_pkg::SPEED_W;
   localparam int unsigned MW   = 1 + 2*PB;
   localparam int unsigned DW   = 41;
   localparam int unsigned FW   = 42;
   localparam int unsigned PW   = PB + FW;
   localparam int unsigned CW   = $clog2(NW + 1);
   localparam logic [PB-1:0] PMAX = {PB{1'b1}};
   localparam logic [DW-1:0] DCAP = DW'(64'h100_0000_0000);

   logic [MW-1:0] mem [INSTRUMENTS];
   logic [MW-1:0] rd_ff;

   ats_pkg::state_type st_ff, st_in;
   logic [ats_pkg::START_W-1:0] start_ff;
   logic [ats_pkg::SPEED_W-1:0] speed_ff;
   logic [AW-1:0]  idx_ff;
   logic [PB-1:0]  cls_ff, prv_ff, rf_ff, rf2_ff, ref_ff;
   logic           first_ff, sold_ff, flip_ff, up_ff, zero_ff;
   logic [NW-1:0]  num_ff;
   logic [PB:0]    rem_ff;
   logic [NW-1:0]  quo_ff;
   logic [CW-1:0]  cnt_ff;
   logic [PW-1:0]  prod_ff;
   ats_pkg::rsp_type rsp_ff;
   logic           rsp_v_ff, rsp_v_in;

   logic [PB-1:0]  clsat, diff;
   logic [PB:0]    rsh, rsub;
   logic [DW-1:0]  delta;
   logic [FW-1:0]  fac;
   logic [20:0]    fac_part;
   logic [PB+20:0] part_prod;
   logic [PB-1:0]  scaled, band, rf2_sel;
   logic [PW-1:0]  rnd;
   logic           flip_now, rsp_free;

   // instrument index modulo the instrument count, by compare and subtract
   function automatic logic [AW-1:0] wrap_index(input logic [ats_pkg::INST_W-1:0] raw);
      logic [ats_pkg::INST_W+16:0] r;
      r = (ats_pkg::INST_W+17)'(raw);
      for (int i = ats_pkg::INST_W-1; i >= 0; i--) begin
         if (r >= ((ats_pkg::INST_W+17)'(INSTRUMENTS) << i))
            r = r - ((ats_pkg::INST_W+17)'(INSTRUMENTS) << i);
      end
      return AW'(r);
   endfunction

   assign rsp_free  = !rsp_v_ff || rsp_ready;
   assign req_ready = (st_ff == ats_pkg::ST_IDLE);
   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_v_in  = ((st_ff == ats_pkg::ST_RESP) && rsp_free) || (rsp_v_ff && !rsp_ready);

   // close saturated to the price width
   always_comb begin
      if (PB >= ats_pkg::PRICE_W) clsat = PB'(req_data.close_price);
      else if ((req_data.close_price >> PB) != '0) clsat = PMAX;
      else clsat = PB'(req_data.close_price);
   end

   assign diff = up_ff ? (cls_ff - prv_ff) : (prv_ff - cls_ff);
   assign rsh  = {rem_ff[PB-1:0], num_ff[NW-1]};
   assign rsub = rsh - {1'b0, prv_ff};

   // quotient capped at 2^40
   always_comb begin
      if (NW > DW && (quo_ff >> DW) != '0) delta = DCAP;
      else if (DW'(quo_ff) > DCAP) delta = DCAP;
      else delta = DW'(quo_ff);
   end
   assign fac = up_ff ? (FW'(65536) + FW'(delta)) : (FW'(65536) - FW'(delta));

   // factor multiplied in two halves, the low half in ST_SCALE and the high half in ST_SCALE_HI
   assign fac_part  = (st_ff == ats_pkg::ST_SCALE) ? fac[20:0] : fac[FW-1:21];
   assign part_prod = (PB+21)'(rf_ff) * (PB+21)'(fac_part);

   // rounding and saturation of a q16 product
   assign rnd = prod_ff + PW'(16'h8000);
   always_comb begin
      if ((rnd >> (PB + 16)) != '0) scaled = PMAX;
      else scaled = PB'(rnd >> 16);
   end
   assign band = scaled;

   always_comb begin
      if (sold_ff) rf2_sel = (rf_ff < rf2_ff) ? rf_ff : rf2_ff;
      else         rf2_sel = (rf_ff > rf2_ff) ? rf_ff : rf2_ff;
   end
   assign flip_now = sold_ff ? (cls_ff > rf2_sel) : (cls_ff < rf2_sel);

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ats_pkg::ST_IDLE:     if (req_valid && req_ready) st_in = ats_pkg::ST_READ;
         ats_pkg::ST_READ:     st_in = first_ff ? ats_pkg::ST_BAND : ats_pkg::ST_LOAD;
         ats_pkg::ST_LOAD:     st_in = ats_pkg::ST_MUL;
         ats_pkg::ST_MUL:      st_in = zero_ff ? ats_pkg::ST_DECIDE : ats_pkg::ST_DIV;
         ats_pkg::ST_DIV:      if (cnt_ff == CW'(1)) st_in = ats_pkg::ST_SCALE;
         ats_pkg::ST_SCALE:    st_in = ats_pkg::ST_SCALE_HI;
         ats_pkg::ST_SCALE_HI: st_in = ats_pkg::ST_CLAMP;
         ats_pkg::ST_CLAMP:    st_in = ats_pkg::ST_DECIDE;
         ats_pkg::ST_DECIDE:   st_in = flip_now ? ats_pkg::ST_BAND : ats_pkg::ST_WRITE;
         ats_pkg::ST_BAND:     st_in = ats_pkg::ST_WRITE;
         ats_pkg::ST_WRITE:    st_in = ats_pkg::ST_RESP;
         ats_pkg::ST_RESP:     if (rsp_free) st_in = ats_pkg::ST_IDLE;
         default:              st_in = ats_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ats_pkg::ST_IDLE;
         rsp_v_ff <= 1'b0;
         start_ff <= ats_pkg::START_W'(3277);
         speed_ff <= ats_pkg::SPEED_W'(65536);
      end else begin
         st_ff    <= st_in;
         rsp_v_ff <= rsp_v_in;
         if (csr_write) begin
            unique case (csr_index)
               ats_pkg::CSR_START: start_ff <= csr_data[ats_pkg::START_W-1:0];
               ats_pkg::CSR_SPEED: speed_ff <= csr_data[ats_pkg::SPEED_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // state memory
   always_ff @(posedge clock) begin
      rd_ff <= mem[idx_ff];
      if (st_ff == ats_pkg::ST_WRITE) mem[idx_ff] <= {sold_ff, ref_ff, cls_ff};
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (st_ff)
         ats_pkg::ST_IDLE: begin
            idx_ff   <= wrap_index(req_data.instrument);
            cls_ff   <= clsat;
            first_ff <= req_data.first_day;
            flip_ff  <= 1'b0;
            sold_ff  <= 1'b0;
         end
         ats_pkg::ST_READ: begin
            prod_ff <= PW'(cls_ff) * PW'(17'h10000 - 17'(start_ff));
         end
         ats_pkg::ST_LOAD: begin
            sold_ff <= rd_ff[MW-1];
            rf_ff   <= rd_ff[2*PB-1:PB];
            prv_ff  <= rd_ff[PB-1:0];
            up_ff   <= cls_ff >= rd_ff[PB-1:0];
            zero_ff <= rd_ff[PB-1:0] == '0;
            rf2_ff  <= rd_ff[2*PB-1:PB];
         end
         ats_pkg::ST_MUL: begin
            num_ff <= NW'(diff) * NW'(speed_ff);
            rem_ff <= '0;
            quo_ff <= '0;
            cnt_ff <= CW'(NW);
         end
         ats_pkg::ST_DIV: begin
            num_ff <= num_ff << 1;
            cnt_ff <= cnt_ff - CW'(1);
            if (!rsub[PB]) begin
               rem_ff <= rsub;
               quo_ff <= {quo_ff[NW-2:0], 1'b1};
            end else begin
               rem_ff <= rsh;
               quo_ff <= {quo_ff[NW-2:0], 1'b0};
            end
         end
         ats_pkg::ST_SCALE: begin
            prod_ff <= fac[FW-1] ? '0 : PW'(part_prod);
            zero_ff <= !up_ff && (delta >= DW'(65536));
         end
         ats_pkg::ST_SCALE_HI: begin
            if (!fac[FW-1]) prod_ff <= prod_ff + (PW'(part_prod) << 21);
         end
         ats_pkg::ST_CLAMP: rf2_ff <= zero_ff ? '0 : scaled;
         ats_pkg::ST_DECIDE: begin
            ref_ff <= rf2_sel;
            if (flip_now) begin
               flip_ff <= 1'b1;
               prod_ff <= PW'(cls_ff) * (sold_ff ? PW'(17'h10000 - 17'(start_ff))
                                                 : PW'(17'h10000 + 17'(start_ff)));
            end
         end
         ats_pkg::ST_BAND: begin
            ref_ff  <= band;
            sold_ff <= first_ff ? 1'b0 : !sold_ff;
         end
         ats_pkg::ST_WRITE: ;
         ats_pkg::ST_RESP: begin
            if (rsp_free) begin
               rsp_ff.instrument_out  <= ats_pkg::INST_W'(idx_ff);
               rsp_ff.reference_level <= ats_pkg::PRICE_W'(ref_ff);
               rsp_ff.sold_flag       <= sold_ff;
               rsp_ff.switched        <= flip_ff;
            end
         end
         default: ;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (st_ff == ats_pkg::ST_RESP) |=> rsp_valid)
      else $error("response not raised");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff != ats_pkg::ST_IDLE) |-> !req_ready)
      else $error("ready while busy");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_data))
      else $error("response changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == ats_pkg::ST_RESP) |-> !(flip_ff && first_ff))
      else $error("switch on first day");
endmodule
`default_nettype wire

@@ verif/accelerating_trailing_stop_reference_checker.sv @@
// checker for the accelerating trailing stop block: watches the request, response and
// register ports, predicts each response from its own per-instrument state and compares
// depends on ats_pkg
`default_nettype none
module accelerating_trailing_stop_reference_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire ats_pkg::req_type              req_data,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire ats_pkg::rsp_type              rsp_data,
   input  wire logic                          csr_write,
   input  wire logic [ats_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ats_pkg::CSR_W-1:0]     csr_data,
   output int                                 fail_count,
   output int                                 pending_levels
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] ONE_Q16   = 64'd65536;
   localparam logic [63:0] DELTA_CAP = 64'd1 << 40;

   logic [ats_pkg::START_W-1:0] band_fraction;
   logic [ats_pkg::SPEED_W-1:0] accel_gain;
   logic                        sold_mem [1024];
   logic [ats_pkg::PRICE_W-1:0] level_mem [1024];
   logic [ats_pkg::PRICE_W-1:0] last_close_mem [1024];
   ats_pkg::rsp_type            expected_levels [$];

   // round half up of a*f/65536, saturated to the price range
   function automatic logic [ats_pkg::PRICE_W-1:0] scale_price(
      logic [ats_pkg::PRICE_W-1:0] a, logic [63:0] f);
      logic [127:0] p;
      p = {96'd0, a} * {64'd0, f};
      p = (p + 128'd32768) >> 16;
      return (p > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
   endfunction

   function automatic logic [63:0] move_ratio(logic [ats_pkg::PRICE_W-1:0] diff,
                                              logic [ats_pkg::PRICE_W-1:0] prv);
      logic [63:0] q;
      q = ({32'd0, diff} * {40'd0, accel_gain}) / {32'd0, prv};
      return (q > DELTA_CAP) ? DELTA_CAP : q;
   endfunction

   function automatic ats_pkg::rsp_type next_level(ats_pkg::req_type r);
      ats_pkg::rsp_type            o;
      logic [9:0]                  idx;
      logic [ats_pkg::PRICE_W-1:0] c, rf, rf2, prv, lvl;
      logic [63:0]                 d;
      logic                        sold, flip;
      idx  = r.instrument;
      c    = r.close_price;
      flip = 1'b0;
      if (r.first_day) begin
         sold = 1'b0;
         lvl  = scale_price(c, ONE_Q16 - band_fraction);
      end else begin
         sold = sold_mem[idx];
         rf   = level_mem[idx];
         prv  = last_close_mem[idx];
         if (prv == 0) begin
            rf2 = rf;
         end else if (c >= prv) begin
            d   = move_ratio(c - prv, prv);
            rf2 = scale_price(rf, ONE_Q16 + d);
         end else begin
            d   = move_ratio(prv - c, prv);
            rf2 = (d >= ONE_Q16) ? '0 : scale_price(rf, ONE_Q16 - d);
         end
         if (sold) begin
            if (rf < rf2) rf2 = rf;
            if (c > rf2) begin
               sold = 1'b0;
               flip = 1'b1;
               lvl  = scale_price(c, ONE_Q16 - band_fraction);
            end else begin
               lvl = rf2;
            end
         end else begin
            if (rf > rf2) rf2 = rf;
            if (c < rf2) begin
               sold = 1'b1;
               flip = 1'b1;
               lvl  = scale_price(c, ONE_Q16 + band_fraction);
            end else begin
               lvl = rf2;
            end
         end
      end
      sold_mem[idx]       = sold;
      level_mem[idx]      = lvl;
      last_close_mem[idx] = c;
      o.instrument_out  = idx;
      o.reference_level = lvl;
      o.sold_flag       = sold;
      o.switched        = flip;
      return o;
   endfunction

   assign pending_levels = expected_levels.size();

   always @(posedge clock) begin
      ats_pkg::rsp_type e;
      if (reset) begin
         band_fraction <= 16'd3277;
         accel_gain    <= 24'd65536;
         fail_count    <= 0;
      end else begin
         if (csr_write) begin
            if (csr_index == ats_pkg::CSR_START) band_fraction <= csr_data[ats_pkg::START_W-1:0];
            else if (csr_index == ats_pkg::CSR_SPEED) accel_gain <= csr_data[ats_pkg::SPEED_W-1:0];
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_levels.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_levels.pop_front();
               if (e !== rsp_data) begin
                  $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) expected_levels.push_back(next_level(req_data));
      end
   end
endmodule
`default_nettype wire

@@ verif/accelerating_trailing_stop_reference_test.sv @@
// testbench top for the accelerating trailing stop block: drives requests and register
// writes, throttles the response side and reports the verdict; uses ats_pkg and the checker
`default_nettype none
module accelerating_trailing_stop_reference_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STOP_CYCLES = 1500000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   ats_pkg::req_type              req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   ats_pkg::rsp_type              rsp_data;
   logic                          csr_write = 1'b0;
   logic [ats_pkg::CSR_IDX_W-1:0] csr_index = ats_pkg::CSR_START;
   logic [ats_pkg::CSR_W-1:0]     csr_data = '0;
   int                            fail_count;
   int                            pending_levels;
   int                            cycle_count = 0;
   logic                          steady = 1'b0;
   logic                          seeded [1024];
   logic [ats_pkg::PRICE_W-1:0]   last_close [1024];

   accelerating_trailing_stop_reference dut (.*);
   accelerating_trailing_stop_reference_checker checker_i (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= STOP_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(negedge clock) rsp_ready = steady || ($urandom_range(99) >= 38);

   task automatic write_csr(logic [ats_pkg::CSR_IDX_W-1:0] idx, logic [ats_pkg::CSR_W-1:0] val);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = val;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_levels != 0) @(negedge clock);
      req_valid = 1'b0;
      repeat (100) @(negedge clock);
   endtask

   task automatic send(logic [9:0] inst, logic [31:0] close, logic first);
      if (!steady && $urandom_range(99) < 38) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data.instrument  = inst;
      req_data.close_price = close;
      req_data.first_day   = first;
      seeded[inst]     = 1'b1;
      last_close[inst] = close;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_random();
      logic [9:0]  inst;
      logic [31:0] c, step;
      logic        first;
      inst = ($urandom_range(99) < 80) ? 10'($urandom_range(15)) : 10'($urandom_range(1023));
      first = !seeded[inst] || ($urandom_range(99) < 5);
      c = seeded[inst] ? last_close[inst] : $urandom;
      case ($urandom_range(9))
         0:       c = $urandom;
         1:       c = '0;
         2:       c = '1;
         3:       c = 32'($urandom_range(65535));
         default: begin
            step = 32'((64'(c) * $urandom_range(80)) / 1000) + 32'($urandom_range(3));
            if ($urandom_range(1)) c = (c > 32'hFFFF_FFFF - step) ? '1 : c + step;
            else c = (c < step) ? '0 : c - step;
         end
      endcase
      send(inst, c, first);
   endtask

   initial begin
      logic [ats_pkg::CSR_W-1:0] start_set [5];
      logic [ats_pkg::CSR_W-1:0] speed_set [5];
      foreach (seeded[i]) seeded[i] = 1'b0;
      start_set = '{24'd3277, 24'd0, 24'd65535, 24'd3277, 24'($urandom_range(65535))};
      speed_set = '{24'd65536, 24'd0, 24'hFFFFFF, 24'd655360, 24'($urandom_range(24'hFFFFFF))};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: index and price extremes, zero previous close, switches both ways
      write_csr(ats_pkg::CSR_START, 24'd3277);
      write_csr(ats_pkg::CSR_SPEED, 24'd65536);
      send(10'd0, 32'h0064_0000, 1'b1);
      send(10'd0, 32'h0070_0000, 1'b0);
      send(10'd0, 32'h0050_0000, 1'b0);
      send(10'd0, 32'h0048_0000, 1'b0);
      send(10'd0, 32'h0090_0000, 1'b0);
      send(10'd1023, 32'hFFFF_FFFF, 1'b1);
      send(10'd1023, 32'hFFFF_FFFF, 1'b0);
      send(10'd1023, 32'h0000_0001, 1'b0);
      send(10'd512, 32'd0, 1'b1);
      send(10'd512, 32'h0001_0000, 1'b0);
      send(10'd512, 32'd0, 1'b0);
      send(10'd341, 32'h5555_5555, 1'b1);
      send(10'd682, 32'hAAAA_AAAA, 1'b1);
      wait_idle();
      write_csr(ats_pkg::CSR_SPEED, 24'hFFFFFF);
      write_csr(ats_pkg::CSR_START, 24'd65535);
      send(10'd0, 32'h0090_0000, 1'b1);
      send(10'd0, 32'h0001_0000, 1'b0);
      send(10'd0, 32'h8000_0000, 1'b0);
      send(10'd0, 32'h0000_0100, 1'b0);
      wait_idle();

      for (int p = 0; p < 5; p++) begin
         write_csr(ats_pkg::CSR_START, start_set[p]);
         write_csr(ats_pkg::CSR_SPEED, speed_set[p]);
         for (int n = 0; n < 376; n++) begin
            steady = (p == 3) && (n < 150);
            send_random();
         end
         steady = 1'b0;
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
